// ===== src/ovl_pkg.sv =====
package ovl_pkg;

    // default list capacity
    localparam int LIST_DEPTH_DEF = 16;

    // fixed field widths
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 4;
    localparam int LEN_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

endpackage

// ===== src/ovl_req_if.sv =====
interface ovl_req_if;
    import ovl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] key_value;
    logic signed [VAL_W-1:0] replacement;

    modport source (output valid, operation, key_value, replacement, input ready);
    modport sink   (input valid, operation, key_value, replacement, output ready);
endinterface

// ===== src/ovl_rsp_if.sv =====
interface ovl_rsp_if;
    import ovl_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] length;

    modport source (output valid, status, position, length, input ready);
    modport sink   (input valid, status, position, length, output ready);
endinterface

// ===== src/ovl_ram.sv =====
module ovl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/ordered_value_list_table.sv =====
// ordered value list table
// keeps up to LIST_DEPTH signed 32-bit values in insertion order in a
// single-port-write, registered-read ram. one request item carries an
// operation (append, search, update, delete), a key and a replacement value;
// each request gives exactly one response item with status, position of the
// first match (search only) and the list length afterwards.
// steps from request accept to response valid:
//   append, full or empty list: accept, then the done state
//   search/update: one read and one compare per entry up to the first
//   match or the end of the list; delete: scan up to the hit, then one read and
//   one write per later entry to close the gap
// the scan runs through one ram read port and one 32-bit comparator, and a
// new request item is taken only once the previous one has left the sequencer.
// i_req.ready is high only while the sequencer is idle; a finished response
// is held in an output register, so the next request can be taken while the
// receiver stalls. a further result then waits in the done state until the
// output register frees up.
// reset (synchronous, active low) empties the list and drops any pending
// response; ram contents are left as they are and never read before written.
module ordered_value_list_table #(
    parameter int LIST_DEPTH = ovl_pkg::LIST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ovl_req_if.sink     i_req,
    ovl_rsp_if.source   o_rsp
);
    import ovl_pkg::*;

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

    // sequencer state
    t_state r_state, n_state;

    // list length
    logic [CW-1:0] r_count, n_count;

    // scan index and latched request
    logic [IW-1:0]        r_idx, n_idx;
    t_op                  r_op, n_op;
    logic [VAL_W-1:0]     r_key, n_key;
    logic [VAL_W-1:0]     r_repl, n_repl;
    t_status              r_status, n_status;
    logic [IW-1:0]        r_pos, n_pos;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [ST_W-1:0]      r_out_status, n_out_status;
    logic [POS_W-1:0]     r_out_pos, n_out_pos;
    logic [LEN_W-1:0]     r_out_len, n_out_len;

    // ram ports
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [VAL_W-1:0]     ram_wdata;
    logic [IW-1:0]        ram_raddr;
    logic [VAL_W-1:0]     ram_rdata;

    // shared index arithmetic and compare
    logic [CW-1:0]        idx_ext;
    logic [CW:0]          idx_p1;
    logic [CW:0]          idx_p2;
    logic                 key_hit;
    logic                 accept;
    logic                 out_free;
    logic [CW+LEN_W-1:0]  len_ext;
    logic [IW+POS_W-1:0]  pos_ext;

    ovl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_ext  = CW'(r_idx);
    assign idx_p1   = {1'b0, idx_ext} + (CW+1)'(1);
    assign idx_p2   = {1'b0, idx_ext} + (CW+1)'(2);
    assign key_hit  = (ram_rdata == r_key);
    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // fields are masked to their widths for deep lists
    assign len_ext  = {{LEN_W{1'b0}}, r_count};
    assign pos_ext  = {{POS_W{1'b0}}, r_pos};

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.position = r_out_pos;
    assign o_rsp.length   = r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_op         <= n_op;
        r_key        <= n_key;
        r_repl       <= n_repl;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_len    <= n_out_len;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_op         = r_op;
        n_key        = r_key;
        n_repl       = r_repl;
        n_status     = r_status;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_len    = r_out_len;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = r_repl;
        ram_raddr    = r_idx;

        // response taken by the receiver
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_req.operation);
                    n_key    = i_req.key_value;
                    n_repl   = i_req.replacement;
                    n_idx    = '0;
                    n_pos    = '0;
                    n_status = ST_OK;
                    if (t_op'(i_req.operation) == OP_APPEND) begin
                        if (r_count == FULL_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            // write straight to the tail
                            ram_we    = 1'b1;
                            ram_waddr = r_count[IW-1:0];
                            ram_wdata = i_req.key_value;
                            n_count   = r_count + CW'(1);
                        end
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (key_hit) begin
                    unique case (r_op)
                        OP_SEARCH: begin
                            n_pos   = r_idx;
                            n_state = S_DONE;
                        end
                        OP_UPDATE: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_idx;
                            ram_wdata = r_repl;
                            n_state   = S_DONE;
                        end
                        OP_DELETE: begin
                            if (idx_p1 < {1'b0, r_count}) begin
                                n_state = S_SHIFT_RD;
                            end else begin
                                // last entry, nothing to close up
                                n_count = r_count - CW'(1);
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else if (idx_p1 == {1'b0, r_count}) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = idx_p1[IW-1:0];
                    n_state = S_READ;
                end
            end
            S_SHIFT_RD: begin
                ram_raddr = idx_p1[IW-1:0];
                n_state   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = idx_p1[IW-1:0];
                if (idx_p2 < {1'b0, r_count}) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = pos_ext[POS_W-1:0];
                    n_out_len    = len_ext[LEN_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
